>>> sv/qdsc_pkg.sv
`timescale 1ns / 1ps

package qdsc_pkg;

   // normals are cut down to this many magnitude bits before squaring
   localparam int RED_BITS       = 30;
   localparam int SCORE_INT_BITS = 5;
   localparam int CFG_BITS       = 8;
   localparam int CSR_IDX_BITS   = 2;

   typedef logic [CSR_IDX_BITS-1:0] csr_idx_type;

   localparam csr_idx_type CSR_NORMAL_WEIGHT = 2'd0;
   localparam csr_idx_type CSR_TIE_MARGIN    = 2'd1;

   localparam logic [CFG_BITS-1:0] NORMAL_WEIGHT_RST = 8'd16;
   localparam logic [CFG_BITS-1:0] TIE_MARGIN_RST    = 8'd0;

   typedef logic [1:0] corner_type;

   // triangles 0 and 1 form diagonal 0-2, triangles 2 and 3 form diagonal 1-3
   localparam corner_type TRI_CORNER [4][3] = '{
      '{2'd0, 2'd1, 2'd2},
      '{2'd0, 2'd2, 2'd3},
      '{2'd0, 2'd1, 2'd3},
      '{2'd1, 2'd2, 2'd3}
   };

endpackage

>>> sv/quad_diagonal_split_chooser.sv
`timescale 1ns / 1ps
// datapath: edge, cross product, normal, reduction and square stages, the 31-step square-root pipeline
//    and the SCORE_FRAC_BITS + 1 step dividers, then the score and output registers
// throughput: one item per cycle; the whole pipeline holds only while a result waits
// reset: synchronous, clears all valid bits, normal_weight to 16 and tie_margin to 0
module quad_diagonal_split_chooser
   import qdsc_pkg::*;
#(
   parameter int COORD_BITS      = 24,
   parameter int SCORE_FRAC_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_p0_x,
   input  logic signed [COORD_BITS-1:0] req_p0_y,
   input  logic signed [COORD_BITS-1:0] req_p0_z,
   input  logic signed [COORD_BITS-1:0] req_p1_x,
   input  logic signed [COORD_BITS-1:0] req_p1_y,
   input  logic signed [COORD_BITS-1:0] req_p1_z,
   input  logic signed [COORD_BITS-1:0] req_p2_x,
   input  logic signed [COORD_BITS-1:0] req_p2_y,
   input  logic signed [COORD_BITS-1:0] req_p2_z,
   input  logic signed [COORD_BITS-1:0] req_p3_x,
   input  logic signed [COORD_BITS-1:0] req_p3_y,
   input  logic signed [COORD_BITS-1:0] req_p3_z,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_split_choice,
   output logic                         rsp_both_degenerate,
   input  logic                         csr_write,
   input  csr_idx_type                  csr_index,
   input  logic [CFG_BITS-1:0]          csr_wdata
);

   // widths along the datapath
   localparam int EW   = COORD_BITS + 1;        // edge
   localparam int PW   = 2 * EW;                // cross product term
   localparam int NW   = PW + 1;                // exact normal component
   localparam int BLW  = $clog2(NW + 1);        // bit length / shift
   localparam int MW   = (NW > RED_BITS) ? NW : RED_BITS;
   localparam int RPW  = 2 * RED_BITS;          // product of reduced components
   localparam int SQW  = RPW + 2;               // sum of squares
   localparam int LW   = RED_BITS + 1;          // normal length
   localparam int DW   = RPW + 3;               // signed dot product
   localparam int DENW = 2 * LW;                // divider operand
   localparam int REMW = DENW + 1;
   localparam int F    = SCORE_FRAC_BITS;
   localparam int QW   = F + 1;
   localparam int NPW  = F + 2;
   localparam int NTW  = NPW + CFG_BITS;
   localparam int SUMW = NTW + 1;
   localparam int SW   = F + SCORE_INT_BITS;
   localparam int CMPW = SW + 1;
   localparam int DVS  = F + 2;                 // divider stages incl. operand stage
   localparam logic [QW-1:0] ONE = {1'b1, {F{1'b0}}};

   logic adv;

   // configuration
   logic [CFG_BITS-1:0] normal_weight_ff;
   logic [CFG_BITS-1:0] tie_margin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_weight_ff <= NORMAL_WEIGHT_RST;
         tie_margin_ff    <= TIE_MARGIN_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_NORMAL_WEIGHT: normal_weight_ff <= csr_wdata;
            CSR_TIE_MARGIN:    tie_margin_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // one global advance; the output register parts the two sides
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   logic signed [COORD_BITS-1:0] pt [4][3];
   assign pt[0][0] = req_p0_x;
   assign pt[0][1] = req_p0_y;
   assign pt[0][2] = req_p0_z;
   assign pt[1][0] = req_p1_x;
   assign pt[1][1] = req_p1_y;
   assign pt[1][2] = req_p1_z;
   assign pt[2][0] = req_p2_x;
   assign pt[2][1] = req_p2_y;
   assign pt[2][2] = req_p2_z;
   assign pt[3][0] = req_p3_x;
   assign pt[3][1] = req_p3_y;
   assign pt[3][2] = req_p3_z;

   // stage 1: triangle edges
   logic signed [EW-1:0] e1_ff [4][3];
   logic signed [EW-1:0] e2_ff [4][3];
   logic                 s1_vld_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int t = 0; t < 4; t++) begin
            for (int d = 0; d < 3; d++) begin
               e1_ff[t][d] <= EW'(pt[TRI_CORNER[t][1]][d]) - EW'(pt[TRI_CORNER[t][0]][d]);
               e2_ff[t][d] <= EW'(pt[TRI_CORNER[t][2]][d]) - EW'(pt[TRI_CORNER[t][0]][d]);
            end
         end
      end
   end

   // stage 2: cross product terms
   logic signed [PW-1:0] pa_ff [4][3];
   logic signed [PW-1:0] pb_ff [4][3];
   logic                 s2_vld_ff;

   for (genvar t = 0; t < 4; t++) begin : g_cross
      for (genvar d = 0; d < 3; d++) begin : g_comp
         localparam int A = (d + 1) % 3;
         localparam int B = (d + 2) % 3;
         always_ff @(posedge clock) begin
            if (adv) begin
               pa_ff[t][d] <= PW'(e1_ff[t][A]) * PW'(e2_ff[t][B]);
               pb_ff[t][d] <= PW'(e1_ff[t][B]) * PW'(e2_ff[t][A]);
            end
         end
      end
   end

   // stage 3: exact normals
   logic signed [NW-1:0] nrm_ff [4][3];
   logic                 s3_vld_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int t = 0; t < 4; t++) begin
            for (int d = 0; d < 3; d++) begin
               nrm_ff[t][d] <= NW'(pa_ff[t][d]) - NW'(pb_ff[t][d]);
            end
         end
      end
   end

   // stage 4: sign and magnitude, zero-normal detect
   logic [NW-1:0] s4_mag_ff [4][3];
   logic          s4_neg_ff [4][3];
   logic          s4_nz_ff  [4];
   logic          s4_vld_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int t = 0; t < 4; t++) begin
            for (int d = 0; d < 3; d++) begin
               s4_neg_ff[t][d] <= nrm_ff[t][d][NW-1];
               s4_mag_ff[t][d] <= nrm_ff[t][d][NW-1] ? NW'(-nrm_ff[t][d]) : NW'(nrm_ff[t][d]);
            end
            s4_nz_ff[t] <= |{nrm_ff[t][0], nrm_ff[t][1], nrm_ff[t][2]};
         end
      end
   end

   // stage 5: bit length of the largest component gives the reduction shift
   logic [BLW-1:0] s5_sh_in  [4];
   logic [BLW-1:0] s5_sh_ff  [4];
   logic [NW-1:0]  s5_mag_ff [4][3];
   logic           s5_neg_ff [4][3];
   logic           s5_nz_ff  [4];
   logic           s5_vld_ff;

   always_comb begin : s5_comb
      logic [NW-1:0] orv;
      int            blen;
      for (int t = 0; t < 4; t++) begin
         orv  = s4_mag_ff[t][0] | s4_mag_ff[t][1] | s4_mag_ff[t][2];
         blen = 0;
         for (int i = 0; i < NW; i++) begin
            if (orv[i]) blen = i + 1;
         end
         s5_sh_in[t] = (blen > RED_BITS) ? BLW'(blen - RED_BITS) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s5_sh_ff  <= s5_sh_in;
         s5_mag_ff <= s4_mag_ff;
         s5_neg_ff <= s4_neg_ff;
         s5_nz_ff  <= s4_nz_ff;
      end
   end

   // stage 6: reduced normal components
   logic [RED_BITS-1:0] s6_red_ff [4][3];
   logic                s6_neg_ff [4][3];
   logic [BLW-1:0]      s6_sh_ff  [4];
   logic                s6_nz_ff  [4];
   logic                s6_vld_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int t = 0; t < 4; t++) begin
            for (int d = 0; d < 3; d++) begin
               s6_red_ff[t][d] <= RED_BITS'(MW'(s5_mag_ff[t][d]) >> s5_sh_ff[t]);
            end
         end
         s6_neg_ff <= s5_neg_ff;
         s6_sh_ff  <= s5_sh_ff;
         s6_nz_ff  <= s5_nz_ff;
      end
   end

   // stage 7: squares for the lengths, component products for the dot
   logic [RPW-1:0] s7_sq_ff  [4][3];
   logic [RPW-1:0] s7_dm_ff  [2][3];
   logic           s7_dn_ff  [2][3];
   logic [BLW-1:0] s7_sh_ff  [4];
   logic           s7_nz_ff  [4];
   logic           s7_vld_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int t = 0; t < 4; t++) begin
            for (int d = 0; d < 3; d++) begin
               s7_sq_ff[t][d] <= RPW'(s6_red_ff[t][d]) * RPW'(s6_red_ff[t][d]);
            end
         end
         for (int s = 0; s < 2; s++) begin
            for (int d = 0; d < 3; d++) begin
               s7_dm_ff[s][d] <= RPW'(s6_red_ff[2*s][d]) * RPW'(s6_red_ff[2*s+1][d]);
               s7_dn_ff[s][d] <= s6_neg_ff[2*s][d] ^ s6_neg_ff[2*s+1][d];
            end
         end
         s7_sh_ff <= s6_sh_ff;
         s7_nz_ff <= s6_nz_ff;
      end
   end

   // stage 8 (square-root stage 0): sums of squares and dot products,
   // then one root bit per stage
   logic [SQW-1:0]       isq_x_ff   [LW+1][4];
   logic [SQW-1:0]       isq_r_ff   [LW+1][4];
   logic signed [DW-1:0] isq_dot_ff [LW+1][2];
   logic [BLW-1:0]       isq_sh_ff  [LW+1][4];
   logic                 isq_nz_ff  [LW+1][4];
   logic                 isq_vld_ff [LW+1];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int t = 0; t < 4; t++) begin
            isq_x_ff[0][t] <= SQW'(s7_sq_ff[t][0]) + SQW'(s7_sq_ff[t][1])
                              + SQW'(s7_sq_ff[t][2]);
            isq_r_ff[0][t] <= '0;
         end
         for (int s = 0; s < 2; s++) begin
            isq_dot_ff[0][s] <=
               (s7_dn_ff[s][0] ? -DW'(s7_dm_ff[s][0]) : DW'(s7_dm_ff[s][0])) +
               (s7_dn_ff[s][1] ? -DW'(s7_dm_ff[s][1]) : DW'(s7_dm_ff[s][1])) +
               (s7_dn_ff[s][2] ? -DW'(s7_dm_ff[s][2]) : DW'(s7_dm_ff[s][2]));
         end
         isq_sh_ff[0] <= s7_sh_ff;
         isq_nz_ff[0] <= s7_nz_ff;
      end
   end

   for (genvar j = 1; j <= LW; j++) begin : g_sqrt
      localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (LW - j));
      logic [SQW-1:0] x_in [4];
      logic [SQW-1:0] r_in [4];

      always_comb begin : step
         logic [SQW-1:0] trial;
         for (int t = 0; t < 4; t++) begin
            trial = isq_r_ff[j-1][t] + BIT;
            if (isq_x_ff[j-1][t] >= trial) begin
               x_in[t] = isq_x_ff[j-1][t] - trial;
               r_in[t] = (isq_r_ff[j-1][t] >> 1) + BIT;
            end else begin
               x_in[t] = isq_x_ff[j-1][t];
               r_in[t] = isq_r_ff[j-1][t] >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            isq_x_ff[j]   <= x_in;
            isq_r_ff[j]   <= r_in;
            isq_dot_ff[j] <= isq_dot_ff[j-1];
            isq_sh_ff[j]  <= isq_sh_ff[j-1];
            isq_nz_ff[j]  <= isq_nz_ff[j-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            isq_vld_ff[j] <= 1'b0;
         end else if (adv) begin
            isq_vld_ff[j] <= isq_vld_ff[j-1];
         end
      end
   end

   // p1: length product for the cosine, lengths aligned to a common shift
   logic [DENW-1:0]      p1_den_in [2];
   logic [LW-1:0]        p1_a_in   [2];
   logic [LW-1:0]        p1_b_in   [2];
   logic                 p1_sv_in  [2];
   logic [DENW-1:0]      p1_den_ff [2];
   logic [LW-1:0]        p1_a_ff   [2];
   logic [LW-1:0]        p1_b_ff   [2];
   logic                 p1_sv_ff  [2];
   logic signed [DW-1:0] p1_dot_ff [2];
   logic                 p1_vld_ff;

   always_comb begin : p1_comb
      logic [LW-1:0]  la;
      logic [LW-1:0]  lb;
      logic [BLW-1:0] sa;
      logic [BLW-1:0] sb;
      for (int s = 0; s < 2; s++) begin
         la = isq_r_ff[LW][2*s][LW-1:0];
         lb = isq_r_ff[LW][2*s+1][LW-1:0];
         sa = isq_sh_ff[LW][2*s];
         sb = isq_sh_ff[LW][2*s+1];
         p1_den_in[s] = DENW'(la) * DENW'(lb);
         p1_a_in[s]   = (sb > sa) ? (la >> (sb - sa)) : la;
         p1_b_in[s]   = (sa > sb) ? (lb >> (sa - sb)) : lb;
         // a zero normal on either triangle disqualifies the split
         p1_sv_in[s]  = isq_nz_ff[LW][2*s] & isq_nz_ff[LW][2*s+1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_den_ff <= p1_den_in;
         p1_a_ff   <= p1_a_in;
         p1_b_ff   <= p1_b_in;
         p1_sv_ff  <= p1_sv_in;
         p1_dot_ff <= isq_dot_ff[LW];
      end
   end

   // dividers: units 0/1 give the cosine of each split, units 2/3 the area term
   logic [DENW-1:0] dv_rem_ff [DVS][4];
   logic [DENW-1:0] dv_den_ff [DVS][4];
   logic            dv_q0_ff  [DVS][4];
   logic [F-1:0]    dv_q_ff   [DVS][4];
   logic            dv_neg_ff [DVS][2];
   logic            dv_sv_ff  [DVS][2];
   logic            dv_vld_ff [DVS];

   always_ff @(posedge clock) begin : dv_load
      logic signed [DW-1:0] dot;
      logic [DW-1:0]        absd;
      logic [LW-1:0]        diff;
      logic [LW:0]          sum;
      if (adv) begin
         for (int s = 0; s < 2; s++) begin
            dot  = p1_dot_ff[s];
            absd = dot[DW-1] ? DW'(-dot) : DW'(dot);
            diff = (p1_a_ff[s] > p1_b_ff[s]) ? (p1_a_ff[s] - p1_b_ff[s])
                                             : (p1_b_ff[s] - p1_a_ff[s]);
            sum  = {1'b0, p1_a_ff[s]} + {1'b0, p1_b_ff[s]};
            dv_rem_ff[0][s]   <= absd[DENW-1:0];
            dv_den_ff[0][s]   <= p1_den_ff[s];
            dv_rem_ff[0][2+s] <= DENW'(diff);
            dv_den_ff[0][2+s] <= DENW'(sum);
            dv_neg_ff[0][s]   <= dot[DW-1];
            dv_sv_ff[0][s]    <= p1_sv_ff[s];
         end
         for (int u = 0; u < 4; u++) begin
            dv_q0_ff[0][u] <= 1'b0;
            dv_q_ff[0][u]  <= '0;
         end
      end
   end

   for (genvar k = 1; k < DVS; k++) begin : g_div
      logic [DENW-1:0] rem_in [4];
      logic            q0_in  [4];
      logic [F-1:0]    q_in   [4];

      if (k == 1) begin : g_first
         // whole part: at or above the divisor the quotient saturates to one
         always_comb begin
            for (int u = 0; u < 4; u++) begin
               rem_in[u] = dv_rem_ff[k-1][u];
               q0_in[u]  = dv_rem_ff[k-1][u] >= dv_den_ff[k-1][u];
               q_in[u]   = '0;
            end
         end
      end else begin : g_frac
         always_comb begin : step
            logic [REMW-1:0] t2;
            logic [REMW-1:0] dn;
            for (int u = 0; u < 4; u++) begin
               t2       = {dv_rem_ff[k-1][u], 1'b0};
               dn       = {1'b0, dv_den_ff[k-1][u]};
               q0_in[u] = dv_q0_ff[k-1][u];
               if (t2 >= dn) begin
                  rem_in[u] = DENW'(t2 - dn);
                  q_in[u]   = {dv_q_ff[k-1][u][F-2:0], 1'b1};
               end else begin
                  rem_in[u] = t2[DENW-1:0];
                  q_in[u]   = {dv_q_ff[k-1][u][F-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[k] <= rem_in;
            dv_q0_ff[k]  <= q0_in;
            dv_q_ff[k]   <= q_in;
            dv_den_ff[k] <= dv_den_ff[k-1];
            dv_neg_ff[k] <= dv_neg_ff[k-1];
            dv_sv_ff[k]  <= dv_sv_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[k] <= dv_vld_ff[k-1];
         end
      end
   end

   // normal term: weight * (1 - cos)
   logic [NTW-1:0] nt_in    [2];
   logic [QW-1:0]  ap_in    [2];
   logic [NTW-1:0] nt_ff    [2];
   logic [QW-1:0]  ap_ff    [2];
   logic           nt_sv_ff [2];
   logic           nt_vld_ff;

   always_comb begin : nt_comb
      logic [QW-1:0]  qc;
      logic [NPW-1:0] np;
      for (int s = 0; s < 2; s++) begin
         qc = dv_q0_ff[DVS-1][s] ? ONE : {1'b0, dv_q_ff[DVS-1][s]};
         np = dv_neg_ff[DVS-1][s] ? (NPW'(ONE) + NPW'(qc)) : (NPW'(ONE) - NPW'(qc));
         nt_in[s] = NTW'(np) * NTW'(normal_weight_ff);
         ap_in[s] = dv_q0_ff[DVS-1][2+s] ? ONE : {1'b0, dv_q_ff[DVS-1][2+s]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nt_ff    <= nt_in;
         ap_ff    <= ap_in;
         nt_sv_ff <= dv_sv_ff[DVS-1];
      end
   end

   // score with saturation to the 5.F format
   logic [SW-1:0] sc_ff    [2];
   logic          sc_sv_ff [2];
   logic          sc_vld_ff;

   always_ff @(posedge clock) begin : sc_reg
      logic [SUMW-1:0] sum;
      if (adv) begin
         for (int s = 0; s < 2; s++) begin
            sum = SUMW'(nt_ff[s]) + SUMW'(ap_ff[s]);
            sc_ff[s] <= (|sum[SUMW-1:SW]) ? '1 : sum[SW-1:0];
         end
         sc_sv_ff <= nt_sv_ff;
      end
   end

   // decision and output register
   logic rsp_choice_ff;
   logic rsp_degen_ff;
   logic beats;

   // diagonal 1-3 must win by more than the margin
   assign beats = (CMPW'(sc_ff[1]) + CMPW'(tie_margin_ff)) < CMPW'(sc_ff[0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_choice_ff <= sc_sv_ff[1] && (!sc_sv_ff[0] || beats);
         rsp_degen_ff  <= !sc_sv_ff[0] && !sc_sv_ff[1];
      end
   end

   // valid bits of the fixed stages
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff     <= 1'b0;
         s2_vld_ff     <= 1'b0;
         s3_vld_ff     <= 1'b0;
         s4_vld_ff     <= 1'b0;
         s5_vld_ff     <= 1'b0;
         s6_vld_ff     <= 1'b0;
         s7_vld_ff     <= 1'b0;
         isq_vld_ff[0] <= 1'b0;
         p1_vld_ff     <= 1'b0;
         dv_vld_ff[0]  <= 1'b0;
         nt_vld_ff     <= 1'b0;
         sc_vld_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (adv) begin
         s1_vld_ff     <= req_valid;
         s2_vld_ff     <= s1_vld_ff;
         s3_vld_ff     <= s2_vld_ff;
         s4_vld_ff     <= s3_vld_ff;
         s5_vld_ff     <= s4_vld_ff;
         s6_vld_ff     <= s5_vld_ff;
         s7_vld_ff     <= s6_vld_ff;
         isq_vld_ff[0] <= s7_vld_ff;
         p1_vld_ff     <= isq_vld_ff[LW];
         dv_vld_ff[0]  <= p1_vld_ff;
         nt_vld_ff     <= dv_vld_ff[DVS-1];
         sc_vld_ff     <= nt_vld_ff;
         rsp_valid_ff  <= sc_vld_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_split_choice    = rsp_choice_ff;
   assign rsp_both_degenerate = rsp_degen_ff;

endmodule
